@@ hdl/mono_page_framebuffer_draw_assert.svh @@
// ----------------------------------------------------------------------------
// mono page framebuffer draw assertion macros
// assertion helpers for the drawing engine, removable with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_ASSERT_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MPF_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define MPF_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define MPF_ASSERT_IMPL(label, clk, rstn, prop)
`define MPF_ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

@@ hdl/mpfd_pkg.sv @@
// ----------------------------------------------------------------------------
// mpfd_pkg
// shared types and constants of the page framebuffer drawing engine
// ----------------------------------------------------------------------------
package mpfd_pkg;

    localparam int DefScreenWidth  = 128;
    localparam int DefScreenHeight = 64;
    localparam int FrameDepth      = 1024;
    localparam int AddrW           = 10;

    localparam logic [2:0] OP_PIXEL = 3'd0;
    localparam logic [2:0] OP_HLINE = 3'd1;
    localparam logic [2:0] OP_VLINE = 3'd2;
    localparam logic [2:0] OP_FILL  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;

    localparam logic [1:0] PEN_CLEAR  = 2'd0;
    localparam logic [1:0] PEN_SET    = 2'd1;
    localparam logic [1:0] PEN_INVERT = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch command and clip
        logic rd_issue;   // issue memory read at current address
        logic wr_issue;   // write modified byte
        logic clr_issue;  // write zero at sweep address
        logic step;       // advance column or page
        logic clr_step;   // advance sweep address
        logic clr_start;  // reset sweep address
        logic rd_cmd;     // issue read of read_addr
        logic out_load;   // load result register
    } mpfd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;      // clipped area is empty or pen mode is invalid
        logic last;       // current byte is last of area
        logic clr_last;   // sweep at last address
        logic is_read;
    } mpfd_stat_t;

endpackage

@@ hdl/mpfd_datapath.sv @@
// ----------------------------------------------------------------------------
// mpfd_datapath
// clipping, address walk, framebuffer memory and result register
// ----------------------------------------------------------------------------
module mpfd_datapath import mpfd_pkg::*; #(
    parameter int ScreenWidth  = DefScreenWidth,
    parameter int ScreenHeight = DefScreenHeight
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mpfd_cmd_t         cmd,
    output mpfd_stat_t        stat,
    input  logic [2:0]        op,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic signed [15:0] span_width,
    input  logic signed [15:0] span_height,
    input  logic [1:0]        pen_mode,
    input  logic [AddrW-1:0]  read_addr,
    output logic [7:0]        read_data,
    output logic              data_valid
);

    localparam int XW = $clog2(ScreenWidth);
    localparam int YW = $clog2(ScreenHeight);
    localparam int PW = (YW > 3) ? YW - 3 : 1;

    logic [7:0] mem [FrameDepth];

    logic signed [17:0] xa, xb, ya, yb, w_e, h_e;
    logic signed [17:0] x0c, x1c, y0c, y1c;
    logic               empty_c;

    logic [XW-1:0] x0_reg, x1m_reg, col_reg;
    logic [YW-1:0] y0_reg, y1m_reg;
    logic [PW-1:0] page_reg, plast_reg;
    logic [1:0]    mode_reg;
    logic          rdop_reg;
    logic [AddrW-1:0] addr_c, clr_reg, raddr_reg;
    logic [7:0]    rdata_reg, mask_c, newb_c;
    logic [YW:0]   base_c, lo_c, hi_c;
    logic [3:0]    lo_off, hi_off;
    logic [7:0]    read_data_reg;
    logic          data_valid_reg;

    always_comb begin
        w_e = 18'(span_width);
        h_e = 18'(span_height);
        if (op == OP_PIXEL || op == OP_VLINE) w_e = 18'sd1;
        if (op == OP_PIXEL || op == OP_HLINE) h_e = 18'sd1;
        xa = 18'(x_pos);
        ya = 18'(y_pos);
        xb = xa + w_e;
        yb = ya + h_e;
        x0c = (xa < 0) ? 18'sd0 : xa;
        y0c = (ya < 0) ? 18'sd0 : ya;
        x1c = (xb > 18'(ScreenWidth)) ? 18'(ScreenWidth) : xb;
        y1c = (yb > 18'(ScreenHeight)) ? 18'(ScreenHeight) : yb;
        empty_c = (w_e <= 0) || (h_e <= 0) || (x0c >= x1c) || (y0c >= y1c)
                  || (pen_mode > PEN_INVERT);
    end

    // mask, address and modified byte for the current page
    always_comb begin
        base_c = {page_reg, 3'b000};
        lo_c   = ({1'b0, y0_reg} > base_c) ? {1'b0, y0_reg} : base_c;
        hi_c   = ({1'b0, y1m_reg} < base_c + (YW+1)'(7)) ? {1'b0, y1m_reg}
                 : base_c + (YW+1)'(7);
        lo_off = 4'(lo_c - base_c);
        hi_off = 4'(hi_c - base_c);
        mask_c = (8'hFF >> (4'd7 - hi_off)) & (8'hFF << lo_off);
        addr_c = AddrW'(32'(col_reg) + 32'(page_reg) * ScreenWidth);
        case (mode_reg)
            PEN_SET:    newb_c = rdata_reg | mask_c;
            PEN_CLEAR:  newb_c = rdata_reg & ~mask_c;
            default:    newb_c = rdata_reg ^ mask_c;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x0_reg    <= XW'(x0c);
            x1m_reg   <= XW'(x1c - 18'sd1);
            y0_reg    <= YW'(y0c);
            y1m_reg   <= YW'(y1c - 18'sd1);
            col_reg   <= XW'(x0c);
            page_reg  <= PW'(y0c >>> 3);
            plast_reg <= PW'((y1c - 18'sd1) >>> 3);
            mode_reg  <= pen_mode;
            rdop_reg  <= (op == OP_READ);
            raddr_reg <= read_addr;
        end else if (cmd.step) begin
            if (col_reg == x1m_reg) begin
                col_reg  <= x0_reg;
                page_reg <= page_reg + PW'(1);
            end else begin
                col_reg <= col_reg + XW'(1);
            end
        end
        if (!aresetn) clr_reg <= '0;
        else if (cmd.clr_start) clr_reg <= '0;
        else if (cmd.clr_step) clr_reg <= clr_reg + AddrW'(1);
        if (cmd.rd_issue) rdata_reg <= mem[addr_c];
        if (cmd.rd_cmd) rdata_reg <= mem[raddr_reg];
        if (cmd.wr_issue) mem[addr_c] <= newb_c;
        if (cmd.clr_issue) mem[clr_reg] <= 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_data_reg  <= 8'h00;
            data_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            read_data_reg  <= rdop_reg ? rdata_reg : 8'h00;
            data_valid_reg <= rdop_reg;
        end
    end

    assign read_data     = read_data_reg;
    assign data_valid    = data_valid_reg;
    assign stat.empty    = empty_c;
    assign stat.last     = (col_reg == x1m_reg) && (page_reg == plast_reg);
    assign stat.clr_last = (clr_reg == AddrW'(FrameDepth - 1));
    assign stat.is_read  = (op == OP_READ);

endmodule

@@ hdl/mpfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpfd_ctrl
// command sequencer: read-modify-write walk, clear sweep and handshake
// ----------------------------------------------------------------------------
module mpfd_ctrl import mpfd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [2:0] op,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  mpfd_stat_t stat,
    output mpfd_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_RD, ST_WR, ST_CLR, ST_RDB, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept, out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign busy     = (state_reg != ST_IDLE) && (state_reg != ST_INIT);

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.clr_issue = 1'b1;
                cmd.clr_step  = 1'b1;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (op == OP_CLEAR) begin
                        cmd.clr_start = 1'b1;
                        state_next    = ST_CLR;
                    end else if (stat.is_read) begin
                        state_next = ST_RDB;
                    end else if (op <= OP_FILL && !stat.empty) begin
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_WR;
            end
            ST_WR: begin
                cmd.wr_issue = 1'b1;
                cmd.step     = 1'b1;
                state_next   = stat.last ? ST_DONE : ST_RD;
            end
            ST_CLR: begin
                cmd.clr_issue = 1'b1;
                cmd.clr_step  = 1'b1;
                if (stat.clr_last) state_next = ST_DONE;
            end
            ST_RDB: begin
                cmd.rd_cmd = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

@@ hdl/mono_page_framebuffer_draw.sv @@
// sequence to m_tvalid: pixel/line/rect read then write each touched byte, then ST_DONE;
// read fetches read_addr, then ST_DONE; clear sweeps the store first; empty draw or
// unused op go straight to ST_DONE, which holds until the output is free
// throughput: one item at a time, next item accepted once the result is on m_tvalid
// reset: synchronous active low, then a sweep zeroes the store, s_tready low during it
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw
// page-organized 1 bpp framebuffer drawing engine, top level
// ----------------------------------------------------------------------------
`include "mono_page_framebuffer_draw_assert.svh"
module mono_page_framebuffer_draw import mpfd_pkg::*; #(
    parameter int SCREEN_WIDTH  = DefScreenWidth,
    parameter int SCREEN_HEIGHT = DefScreenHeight
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0], x_pos[18:3], y_pos[34:19], span_width[50:35],
    // span_height[66:51], pen_mode[68:67], read_addr[78:69]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], data_valid[8]
    output logic [15:0] m_tdata
);

    mpfd_cmd_t  cmd;
    mpfd_stat_t stat;
    logic       busy;
    logic [7:0] read_data;
    logic       data_valid;

    mpfd_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .op(s_tdata[2:0]), .m_tvalid, .m_tready,
        .stat, .cmd, .busy
    );

    mpfd_datapath #(.ScreenWidth(SCREEN_WIDTH), .ScreenHeight(SCREEN_HEIGHT)) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .op(s_tdata[2:0]),
        .x_pos(s_tdata[18:3]),
        .y_pos(s_tdata[34:19]),
        .span_width(s_tdata[50:35]),
        .span_height(s_tdata[66:51]),
        .pen_mode(s_tdata[68:67]),
        .read_addr(s_tdata[78:69]),
        .read_data, .data_valid
    );

    assign m_tdata = {7'd0, data_valid, read_data};

    `MPF_ASSERT_NEVER(a_no_accept_busy, aclk, aresetn, s_tready && busy)
    `MPF_ASSERT_NEVER(a_rw_excl, aclk, aresetn, cmd.wr_issue && cmd.clr_issue)
    `MPF_ASSERT_IMPL(a_out_after_load, aclk, aresetn, cmd.out_load |=> m_tvalid)

endmodule
